/* rtl/assert_macros.svh */
// Assertion helper macros used by the checker file dnat_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in the same cycle implies consequent.
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/dnat_pkg.sv */
// Shared types, codes and the key hash for the destination NAT block.
// No dependencies.
package dnat_pkg;

  localparam int KEY_W   = 104;  // src ip, dst ip, protocol, src port, dst port
  localparam int ACT_W   = 56;   // rule number, target ip, target port
  localparam int ENTRY_W = KEY_W + ACT_W;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] HDR_L4 = 2'd2;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [1:0] WS_OK   = 2'd0;
  localparam logic [1:0] WS_FULL = 2'd1;
  localparam logic [1:0] WS_NONE = 2'd2;

  localparam logic REG_PORT_LOW  = 1'b0;
  localparam logic REG_PORT_HIGH = 1'b1;

  localparam logic [15:0] PORT_LOW_RST  = 16'd8000;
  localparam logic [15:0] PORT_HIGH_RST = 16'd8100;
  localparam logic [15:0] CSUM_ONES     = 16'hFFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CALC,
    S_DONE
  } dnat_state_t;

  // XOR fold of the key down to 16 bits.
  function automatic logic [15:0] dnat_hash16(input logic [KEY_W-1:0] key);
    logic [15:0] h;
    h = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      h = {h[14:0], h[15]} ^ {8'd0, key[8*i +: 8]};
    end
    return h;
  endfunction

endpackage

/* rtl/dnat_intf.sv */
// Valid/ready channel interfaces for packet headers and results.
// Depends on nothing but plain logic types.
interface dnat_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  header_status;
  logic [63:0] ip_head_a;
  logic [15:0] ttl_protocol;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] l4_sport;
  logic [15:0] l4_dport;
  logic [15:0] l4_checksum;
  logic [7:0]  rule_number;
  logic [31:0] xlat_ip;
  logic [15:0] xlat_port;

  modport source (output valid, op, header_status, ip_head_a, ttl_protocol, src_ip, dst_ip,
                  l4_sport, l4_dport, l4_checksum, rule_number, xlat_ip, xlat_port,
                  input ready);
  modport sink (input valid, op, header_status, ip_head_a, ttl_protocol, src_ip, dst_ip,
                l4_sport, l4_dport, l4_checksum, rule_number, xlat_ip, xlat_port,
                output ready);
endinterface

interface dnat_out_if;
  logic        valid;
  logic        ready;
  logic        forwarded;
  logic [31:0] out_dst_ip;
  logic [15:0] out_dst_port;
  logic [15:0] out_ip_checksum;
  logic [15:0] out_l4_checksum;
  logic [7:0]  matched_rule;
  logic [1:0]  write_status;

  modport source (output valid, forwarded, out_dst_ip, out_dst_port, out_ip_checksum,
                  out_l4_checksum, matched_rule, write_status, input ready);
  modport sink (input valid, forwarded, out_dst_ip, out_dst_port, out_ip_checksum,
                out_l4_checksum, matched_rule, write_status, output ready);
endinterface

/* rtl/dnat_rule_mem.sv */
// Rule table storage: one synchronous memory, one write and one registered read port.
// Uses dnat_pkg for the entry width.
module dnat_rule_mem #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic                        clk,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [dnat_pkg::ENTRY_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [dnat_pkg::ENTRY_W-1:0] wr_data
);
  import dnat_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

/* rtl/dnat_csum.sv */
// Two-stage checksum unit: full IP header checksum and incremental L4 update.
// Uses dnat_pkg for constants.
module dnat_csum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] head,
  input  logic [15:0] ttlp,
  input  logic [31:0] sip,
  input  logic [31:0] dip,
  input  logic [15:0] dport,
  input  logic [15:0] l4c,
  input  logic [31:0] nip,
  input  logic [15:0] nport,
  output logic        done,
  output logic [15:0] ip_csum,
  output logic [15:0] l4_csum
);
  import dnat_pkg::*;

  logic        stg1_r, done_r;
  logic [19:0] acc_ip_r;
  logic [18:0] acc_l4_r;
  logic        udp_r, keep_zero_r;
  logic [15:0] ip_csum_r, l4_csum_r;
  logic [16:0] ip_f1, l4_f1;
  logic [15:0] ip_f2, l4_f2, l4_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg1_r <= start;
      done_r <= stg1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_ip_r <= 20'(head[63:48]) + 20'(head[47:32]) + 20'(head[31:16]) + 20'(head[15:0])
                + 20'(ttlp) + 20'(sip[31:16]) + 20'(sip[15:0])
                + 20'(nip[31:16]) + 20'(nip[15:0]);
      acc_l4_r <= {3'b000, ~l4c} + {3'b000, ~dip[31:16]} + {3'b000, ~dip[15:0]}
                + {3'b000, ~dport}
                + 19'(nip[31:16]) + 19'(nip[15:0]) + 19'(nport);
      udp_r       <= (ttlp[7:0] == PROTO_UDP);
      keep_zero_r <= (ttlp[7:0] == PROTO_UDP) && (l4c == 16'd0);
    end
  end

  // Two end-around folds bring either sum into 16 bits.
  always_comb begin
    ip_f1 = 17'(acc_ip_r[15:0]) + 17'(acc_ip_r[19:16]);
    ip_f2 = ip_f1[15:0] + 16'(ip_f1[16]);
    l4_f1 = 17'(acc_l4_r[15:0]) + 17'(acc_l4_r[18:16]);
    l4_f2 = l4_f1[15:0] + 16'(l4_f1[16]);
    l4_new = ~l4_f2;
    if (keep_zero_r) begin
      l4_new = 16'd0;
    end else if (udp_r && (l4_new == 16'd0)) begin
      l4_new = CSUM_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (stg1_r) begin
      ip_csum_r <= ~ip_f2;
      l4_csum_r <= l4_new;
    end
  end

  assign done    = done_r;
  assign ip_csum = ip_csum_r;
  assign l4_csum = l4_csum_r;
endmodule

/* rtl/five_tuple_dnat_rewrite_top.sv */
// Destination NAT rewrite top level: controller, hashed rule table probe, result register.
// Uses dnat_pkg, dnat_intf, dnat_rule_mem and dnat_csum.
//
// Channels: in_if carries one item per transfer, either a packet header (op 0) or a
// rule write (op 1). out_if returns exactly one result per item, in order.
// Configuration: cfg_we with cfg_index 0 writes port_low, index 1 writes port_high.
// Rules live in a hashed, open-addressed table: the key hash picks a start slot and
// the controller probes forward one slot per cycle through the synchronous memory
// until it finds the key, an empty slot, or has visited all TABLE_ENTRIES slots.
// Flow: an item that needs no lookup goes from idle straight to the done state and
// then into the output register. A lookup probes the table as above, and a forwarded
// packet then passes through the checksum unit before the done state. The worst case
// is TABLE_ENTRIES probes. One item is handled at a time: the next transfer is taken
// in the cycle after the result is loaded.
// Reset clears all valid bits, restores the port range to 8000..8100 and empties the
// result register; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the block finishes
// the next item and waits with it until the register is taken.
module five_tuple_dnat_rewrite_top #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  dnat_in_if.sink     in_if,
  dnat_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import dnat_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  dnat_state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, probes_r, probes_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic slot_valid_r;
  logic [15:0] port_low_r, port_high_r;

  // held item
  logic        op_r;
  logic [63:0] head_r;
  logic [15:0] ttlp_r, l4c_r;
  logic [KEY_W-1:0] key_r;
  logic [ACT_W-1:0] act_r;

  // pending result and output register
  logic        res_fwd_r, out_valid_r;
  logic [31:0] res_ip_r;
  logic [15:0] res_port_r, res_ipc_r, res_l4_r;
  logic [7:0]  res_rule_r;
  logic [1:0]  res_ws_r;
  logic        o_fwd_r;
  logic [31:0] o_ip_r;
  logic [15:0] o_port_r, o_ipc_r, o_l4_r;
  logic [7:0]  o_rule_r;
  logic [1:0]  o_ws_r;

  logic in_xfer, elig_in, slot_valid, hit, empty, last, mem_we, csum_start, emit;
  logic [KEY_W-1:0] key_in;
  logic [15:0] h16;
  logic [IDX_W-1:0] h_idx, h_raw, idx_inc;
  logic [ENTRY_W-1:0] rd_data;
  logic        csum_done;
  logic [15:0] csum_ip, csum_l4;

  assign in_xfer = in_if.valid && in_if.ready;
  assign key_in  = {in_if.src_ip, in_if.dst_ip, in_if.ttl_protocol[7:0],
                    in_if.l4_sport, in_if.l4_dport};
  assign elig_in = (in_if.header_status == HDR_L4)
                && ((in_if.ttl_protocol[7:0] == PROTO_TCP)
                    || (in_if.ttl_protocol[7:0] == PROTO_UDP))
                && (in_if.l4_dport >= port_low_r) && (in_if.l4_dport <= port_high_r);

  // Fold the hash to an index, then wrap into the table.
  assign h16   = dnat_hash16(key_in);
  assign h_raw = h16[IDX_W-1:0] ^ IDX_W'(h16 >> (16 - IDX_W));
  assign h_idx = ({1'b0, h_raw} >= (IDX_W+1)'(TABLE_ENTRIES))
               ? IDX_W'({1'b0, h_raw} - (IDX_W+1)'(TABLE_ENTRIES)) : h_raw;
  assign idx_inc = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);

  // Valid bit is read alongside the memory and, like the read data, is registered from the address.
  assign slot_valid = slot_valid_r;
  assign hit   = slot_valid && (rd_data[ENTRY_W-1 -: KEY_W] == key_r);
  assign empty = !slot_valid;
  assign last  = (probes_r == IDX_LAST);
  assign emit  = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    probes_nxt = probes_r;
    mem_we     = 1'b0;
    csum_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt    = h_idx;
          probes_nxt = '0;
          state_nxt  = ((in_if.op == OP_WRITE) || elig_in) ? S_PROBE : S_DONE;
        end
      end
      S_PROBE: begin
        if (hit || empty) begin
          if (op_r == OP_WRITE) begin
            mem_we    = 1'b1;
            state_nxt = S_DONE;
          end else if (hit) begin
            csum_start = 1'b1;
            state_nxt  = S_CALC;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt    = idx_inc;
          probes_nxt = probes_r + IDX_W'(1);
        end
      end
      S_CALC: begin
        if (csum_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      valid_r      <= '0;
      slot_valid_r <= 1'b0;
      port_low_r   <= PORT_LOW_RST;
      port_high_r  <= PORT_HIGH_RST;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= valid_r[idx_nxt];
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we && empty) begin
        valid_r[idx_r] <= 1'b1;
      end
      if (cfg_we && (cfg_index == REG_PORT_LOW)) begin
        port_low_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_PORT_HIGH)) begin
        port_high_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    probes_r <= probes_nxt;
    if (in_xfer) begin
      op_r       <= in_if.op;
      head_r     <= in_if.ip_head_a;
      ttlp_r     <= in_if.ttl_protocol;
      l4c_r      <= in_if.l4_checksum;
      key_r      <= key_in;
      act_r      <= {in_if.rule_number, in_if.xlat_ip, in_if.xlat_port};
      res_fwd_r  <= 1'b0;
      res_ip_r   <= in_if.dst_ip;
      res_port_r <= in_if.l4_dport;
      res_ipc_r  <= 16'd0;
      res_l4_r   <= in_if.l4_checksum;
      res_rule_r <= 8'd0;
      res_ws_r   <= WS_NONE;
    end
    if (state_r == S_PROBE) begin
      if (op_r == OP_WRITE) begin
        if (hit || empty) begin
          res_ws_r <= WS_OK;
        end else if (last) begin
          res_ws_r <= WS_FULL;
        end
      end else if (hit) begin
        res_rule_r <= rd_data[55:48];
        res_ip_r   <= rd_data[47:16];
        res_port_r <= rd_data[15:0];
      end
    end
    if ((state_r == S_CALC) && csum_done) begin
      res_fwd_r <= 1'b1;
      res_ipc_r <= csum_ip;
      res_l4_r  <= csum_l4;
    end
    if (emit) begin
      o_fwd_r  <= res_fwd_r;
      o_ip_r   <= res_ip_r;
      o_port_r <= res_port_r;
      o_ipc_r  <= res_ipc_r;
      o_l4_r   <= res_l4_r;
      o_rule_r <= res_rule_r;
      o_ws_r   <= res_ws_r;
    end
  end

  dnat_rule_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_addr (idx_nxt),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (idx_r),
    .wr_data ({key_r, act_r})
  );

  dnat_csum u_csum (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (csum_start),
    .head    (head_r),
    .ttlp    (ttlp_r),
    .sip     (key_r[103:72]),
    .dip     (key_r[71:40]),
    .dport   (key_r[15:0]),
    .l4c     (l4c_r),
    .nip     (rd_data[47:16]),
    .nport   (rd_data[15:0]),
    .done    (csum_done),
    .ip_csum (csum_ip),
    .l4_csum (csum_l4)
  );

  assign in_if.ready            = (state_r == S_IDLE);
  assign out_if.valid           = out_valid_r;
  assign out_if.forwarded       = o_fwd_r;
  assign out_if.out_dst_ip      = o_ip_r;
  assign out_if.out_dst_port    = o_port_r;
  assign out_if.out_ip_checksum = o_ipc_r;
  assign out_if.out_l4_checksum = o_l4_r;
  assign out_if.matched_rule    = o_rule_r;
  assign out_if.write_status    = o_ws_r;
endmodule

/* rtl/dnat_checker.sv */
// Port-level checker for the destination NAT top level, attached by bind.
// Uses assert_macros.svh and dnat_pkg.
`include "assert_macros.svh"

module dnat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        forwarded,
  input logic [15:0] out_ip_checksum,
  input logic [7:0]  matched_rule,
  input logic [1:0]  write_status
);
  import dnat_pkg::*;

  // A stalled result stays offered.
  `AST_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // Rule writes never report a rewrite.
  `AST_IMP(a_wr_nofwd, clk, rst_n, out_valid && (write_status != WS_NONE), !forwarded)
  // A passed-through packet carries no rule and a zero IP checksum.
  `AST_IMP(a_pass, clk, rst_n, out_valid && !forwarded,
           (matched_rule == 8'd0) && (out_ip_checksum == 16'd0))
  // Forwarded results come from packets only.
  `AST_IMP(a_fwd_pkt, clk, rst_n, out_valid && forwarded, write_status == WS_NONE)
endmodule

bind five_tuple_dnat_rewrite_top dnat_checker u_dnat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .forwarded       (out_if.forwarded),
  .out_ip_checksum (out_if.out_ip_checksum),
  .matched_rule    (out_if.matched_rule),
  .write_status    (out_if.write_status)
);

/* bench/dnat_tb_types.sv */
// Stimulus and result records for the destination NAT bench.
// Depends on dnat_pkg.
package dnat_tb_types;
  import dnat_pkg::*;

  typedef struct packed {
    logic        op;
    logic [1:0]  header_status;
    logic [63:0] ip_head_a;
    logic [15:0] ttl_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [15:0] l4_checksum;
    logic [7:0]  rule_number;
    logic [31:0] xlat_ip;
    logic [15:0] xlat_port;
  } hdr_item_t;

  typedef struct packed {
    logic        forwarded;
    logic [31:0] dst_ip;
    logic [15:0] l4_dport;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic [7:0]  matched_rule;
    logic [1:0]  write_status;
  } nat_result_t;
endpackage

/* bench/testbench.sv */
// Testbench for five_tuple_dnat_rewrite_top: directed and random headers and rule writes,
// predicted against an in-bench rule table. Depends on dnat_pkg, dnat_tb_types, dnat_intf.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dnat_pkg::*;
  import dnat_tb_types::*;

  localparam int NRULES = 256;
  localparam int WATCHDOG = 20000;

  logic clk, rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_wdata;

  dnat_in_if  in_if ();
  dnat_out_if out_if ();

  five_tuple_dnat_rewrite_top #(.TABLE_ENTRIES(NRULES)) uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata));

  // predictor state
  logic [15:0]  pr_low, pr_high;
  logic [103:0] tbl_key [NRULES];
  logic [55:0]  tbl_act [NRULES];
  bit           tbl_used [NRULES];
  int           tbl_count;

  nat_result_t expected_q[$];
  int errors;
  int idle_count;
  bit idle_on;       // random receiver gaps enabled
  bit hold_rx;       // long receiver hold-off
  bit tx_gaps;
  hdr_item_t key_pool[$];  // written rules, reused to get matches

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] fold16(logic [31:0] s);
    s = (s & 32'hFFFF) + (s >> 16);
    s = (s & 32'hFFFF) + (s >> 16);
    return s[15:0];
  endfunction

  function automatic nat_result_t predict_rewrite(hdr_item_t it);
    nat_result_t r;
    logic [7:0] proto;
    logic [103:0] key;
    int slot;
    logic [31:0] nip, acc;
    logic [15:0] nport, l4n;
    proto = it.ttl_protocol[7:0];
    key = {it.src_ip, it.dst_ip, proto, it.l4_sport, it.l4_dport};
    r = '{forwarded: 1'b0, dst_ip: it.dst_ip, l4_dport: it.l4_dport, ip_checksum: 16'd0,
          l4_checksum: it.l4_checksum, matched_rule: 8'd0, write_status: WS_NONE};
    slot = -1;
    for (int i = 0; i < NRULES; i++)
      if (slot < 0 && tbl_used[i] && tbl_key[i] == key) slot = i;
    if (it.op == OP_WRITE) begin
      if (slot < 0 && tbl_count < NRULES) begin
        for (int i = 0; i < NRULES; i++)
          if (slot < 0 && !tbl_used[i]) slot = i;
        tbl_used[slot] = 1'b1;
        tbl_key[slot] = key;
        tbl_count++;
      end
      if (slot < 0) r.write_status = WS_FULL;
      else begin
        tbl_act[slot] = {it.rule_number, it.xlat_ip, it.xlat_port};
        r.write_status = WS_OK;
      end
      return r;
    end
    if (it.header_status != HDR_L4 || (proto != PROTO_TCP && proto != PROTO_UDP)) return r;
    if (it.l4_dport < pr_low || it.l4_dport > pr_high || slot < 0) return r;
    nip = tbl_act[slot][47:16];
    nport = tbl_act[slot][15:0];
    acc = '0;
    for (int w = 0; w < 4; w++) acc += it.ip_head_a[48-16*w +: 16];
    acc += it.ttl_protocol + it.src_ip[31:16] + it.src_ip[15:0] + nip[31:16] + nip[15:0];
    r.ip_checksum = ~fold16(acc);
    if (proto == PROTO_UDP && it.l4_checksum == 0) l4n = '0;
    else begin
      acc = {16'd0, ~it.l4_checksum} + {16'd0, ~it.dst_ip[31:16]} +
            {16'd0, ~it.dst_ip[15:0]} + {16'd0, ~it.l4_dport} +
            nip[31:16] + nip[15:0] + nport;
      l4n = ~fold16(acc);
      if (proto == PROTO_UDP && l4n == 0) l4n = CSUM_ONES;
    end
    r.forwarded = 1'b1;
    r.dst_ip = nip;
    r.l4_dport = nport;
    r.l4_checksum = l4n;
    r.matched_rule = tbl_act[slot][55:48];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task automatic send_header(hdr_item_t it);
    int gap;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1;
    in_if.op <= it.op; in_if.header_status <= it.header_status;
    in_if.ip_head_a <= it.ip_head_a; in_if.ttl_protocol <= it.ttl_protocol;
    in_if.src_ip <= it.src_ip; in_if.dst_ip <= it.dst_ip;
    in_if.l4_sport <= it.l4_sport; in_if.l4_dport <= it.l4_dport;
    in_if.l4_checksum <= it.l4_checksum; in_if.rule_number <= it.rule_number;
    in_if.xlat_ip <= it.xlat_ip; in_if.xlat_port <= it.xlat_port;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_q.push_back(predict_rewrite(it));
    if (it.op == OP_WRITE) key_pool.push_back(it);
  endtask

  // result checker
  always @(posedge clk) begin
    nat_result_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      idle_count <= 0;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        w = expected_q.pop_front();
        if (out_if.forwarded != w.forwarded)
          report_mismatch("forwarded", 64'(out_if.forwarded), 64'(w.forwarded));
        if (out_if.out_dst_ip != w.dst_ip)
          report_mismatch("dst_ip", 64'(out_if.out_dst_ip), 64'(w.dst_ip));
        if (out_if.out_dst_port != w.l4_dport)
          report_mismatch("l4_dport", 64'(out_if.out_dst_port), 64'(w.l4_dport));
        if (out_if.out_ip_checksum != w.ip_checksum)
          report_mismatch("ip_checksum", 64'(out_if.out_ip_checksum), 64'(w.ip_checksum));
        if (out_if.out_l4_checksum != w.l4_checksum)
          report_mismatch("l4_checksum", 64'(out_if.out_l4_checksum), 64'(w.l4_checksum));
        if (out_if.matched_rule != w.matched_rule)
          report_mismatch("matched_rule", 64'(out_if.matched_rule), 64'(w.matched_rule));
        if (out_if.write_status != w.write_status)
          report_mismatch("write_status", 64'(out_if.write_status), 64'(w.write_status));
      end
    end else if (in_if.valid && in_if.ready) idle_count <= 0;
    else idle_count <= idle_count + 1;
  end

  // receiver: random gap bursts, or a long hold-off
  initial begin
    int n;
    out_if.ready = 0;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_if.ready <= 0;
        n = 0;
        while (n < 300) begin
          @(posedge clk);
          n++;
        end
        hold_rx = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_if.ready <= 1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    wait (idle_count >= WATCHDOG);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic drain;
    in_if.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    // a probe of the full table may still be in flight
    repeat (NRULES + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == REG_PORT_LOW) pr_low = val; else pr_high = val;
  endtask

  function automatic hdr_item_t rand_item();
    hdr_item_t it;
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(hdr_item_t)-1:0];
    it.header_status = 2'($urandom_range(0, 2));
    return it;
  endfunction

  function automatic hdr_item_t make_rule(logic [7:0] proto);
    hdr_item_t it;
    it = rand_item();
    it.op = OP_WRITE;
    it.ttl_protocol[7:0] = proto;
    it.l4_dport = 16'(pr_low + $urandom_range(0, 40));
    return it;
  endfunction

  // a packet hitting a stored rule, with the header fields randomized
  function automatic hdr_item_t packet_from(hdr_item_t rule);
    hdr_item_t it;
    it = rand_item();
    it.op = OP_PACKET;
    it.header_status = HDR_L4;
    it.ttl_protocol[7:0] = rule.ttl_protocol[7:0];
    it.src_ip = rule.src_ip; it.dst_ip = rule.dst_ip;
    it.l4_sport = rule.l4_sport; it.l4_dport = rule.l4_dport;
    return it;
  endfunction

  function automatic bit predict_l4_zero(hdr_item_t it);
    logic [31:0] acc;
    logic [31:0] nip;
    logic [15:0] nport;
    nip = '0; nport = '0;  // target of the updated rule
    acc = {16'd0, ~it.l4_checksum} + {16'd0, ~it.dst_ip[31:16]} +
          {16'd0, ~it.dst_ip[15:0]} + {16'd0, ~it.l4_dport} +
          nip[31:16] + nip[15:0] + nport;
    return fold16(acc) == 16'hFFFF;
  endfunction

  task automatic test_directed;
    hdr_item_t r, p;
    r = make_rule(PROTO_UDP);
    r.xlat_ip = '1; r.xlat_port = '1; r.rule_number = '1;
    send_header(r);
    p = packet_from(r); p.l4_checksum = '0; send_header(p);          // zero UDP checksum
    p = packet_from(r); p.ip_head_a = '1; p.ttl_protocol[15:8] = '1; send_header(p);
    p = packet_from(r); p.header_status = 2'd1; send_header(p);      // header incomplete
    p = packet_from(r); p.header_status = 2'd0; send_header(p);
    r.xlat_ip = '0; r.xlat_port = '0; r.rule_number = '0;
    send_header(r);                                                   // update in place
    p = packet_from(r); p.ip_head_a = '0; p.ttl_protocol[15:8] = '0; send_header(p);
    // UDP computed zero: choose l4 so that the sum folds to all ones
    p = packet_from(r); p.dst_ip = r.dst_ip;
    for (int c = 1; c < 65536; c++) begin
      p.l4_checksum = 16'(c);
      if (predict_l4_zero(p)) break;
    end
    send_header(p);
    r = make_rule(PROTO_TCP);
    send_header(r);
    p = packet_from(r); send_header(p);
    p = packet_from(r); p.l4_checksum = '0; send_header(p);
    r = make_rule(8'd1);                                              // other protocol
    send_header(r);
    p = packet_from(r); send_header(p);
    p = rand_item(); p.op = OP_PACKET; send_header(p);                // no rule
    drain();
  endtask

  task automatic test_port_ranges;
    hdr_item_t r;
    write_reg(REG_PORT_LOW, 16'd0);
    write_reg(REG_PORT_HIGH, 16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      r = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_header(packet_from(r));
    end
    r = make_rule(PROTO_TCP); r.l4_dport = '0; send_header(r); send_header(packet_from(r));
    r = make_rule(PROTO_UDP); r.l4_dport = '1; send_header(r); send_header(packet_from(r));
    drain();
    write_reg(REG_PORT_LOW, 16'd9000);   // empty range
    write_reg(REG_PORT_HIGH, 16'd10);
    for (int i = 0; i < 6; i++) send_header(packet_from(key_pool[i % key_pool.size()]));
    drain();
    write_reg(REG_PORT_LOW, PORT_LOW_RST);
    write_reg(REG_PORT_HIGH, PORT_HIGH_RST);
  endtask

  task automatic test_random(int count);
    hdr_item_t it;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 9);
      if (k < 2 || key_pool.size() == 0)
        it = make_rule($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);
      else if (k < 8) begin
        it = packet_from(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        if ($urandom_range(0, 7) == 0) it.l4_checksum = '0;
      end else if (k == 8) begin
        it = rand_item(); it.op = OP_PACKET;
      end else it = rand_item();
      send_header(it);
    end
  endtask

  task automatic test_backpressure;
    hdr_item_t r;
    hold_rx = 1;
    for (int i = 0; i < 20; i++) begin
      r = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_header(packet_from(r));
    end
    drain();
  endtask

  task automatic test_full_table;
    hdr_item_t r;
    while (tbl_count < NRULES) begin
      r = make_rule(PROTO_TCP);
      send_header(r);
    end
    r = make_rule(PROTO_UDP); send_header(r);                         // full
    send_header(packet_from(r));
    send_header(key_pool[0]);                                         // update still allowed
    for (int i = 0; i < 30; i++)
      send_header(packet_from(key_pool[$urandom_range(0, key_pool.size() - 1)]));
    drain();
  endtask

  initial begin
    idle_on = 1; hold_rx = 0; tx_gaps = 1;
    tbl_count = 0;
    for (int i = 0; i < NRULES; i++) tbl_used[i] = 0;
    pr_low = PORT_LOW_RST; pr_high = PORT_HIGH_RST;
    rst_n = 0; cfg_we = 0; cfg_index = REG_PORT_LOW; cfg_wdata = 0;
    in_if.valid = 0; in_if.op = 0; in_if.header_status = 0; in_if.ip_head_a = 0;
    in_if.ttl_protocol = 0; in_if.src_ip = 0; in_if.dst_ip = 0; in_if.l4_sport = 0;
    in_if.l4_dport = 0; in_if.l4_checksum = 0; in_if.rule_number = 0;
    in_if.xlat_ip = 0; in_if.xlat_port = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_port_ranges();
    test_random(500);
    drain();
    write_reg(REG_PORT_LOW, 16'd7990);
    write_reg(REG_PORT_HIGH, 16'd8050);
    test_backpressure();
    test_random(300);
    drain();
    test_full_table();
    // last part: no idling on either side
    idle_on = 0; tx_gaps = 0;
    test_random(200);
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
